// ----- rtl/arre_pkg.sv -----
// Package with the shared constants of the attack/release ramp envelope.
`default_nettype none

package arre_pkg;

	// Width of the configuration register index.
	localparam int unsigned REG_IDX_BITS = 2;

	// Configuration register indexes.
	localparam logic [REG_IDX_BITS-1:0] REG_TOP_GAIN        = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_SAMPLES  = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_SAMPLES = 2'd2;

	// Envelope phase codes.
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_ATTACK  = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/arre_if.sv -----
// Channel interfaces of the attack/release ramp envelope: trigger, level and configuration.
`default_nettype none

interface arre_in_if;
	logic valid;
	logic ready;
	logic trigger;

	modport source (output valid, output trigger, input ready);
	modport sink (input valid, input trigger, output ready);
endinterface

interface arre_out_if #(
	parameter int unsigned LEVEL_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] level;
	logic                  active;

	modport source (output valid, output level, output active, input ready);
	modport sink (input valid, input level, input active, output ready);
endinterface

interface arre_cfg_if #(
	parameter int unsigned DATA_BITS = 20
);
	logic                              valid;
	logic                              ready;
	logic [arre_pkg::REG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]              data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/attack_release_ramp_envelope.sv -----
// Top level of the linear attack/release ramp envelope generator.
`default_nettype none

// One transaction on in_chan is one sample tick and yields exactly one transaction on
// out_chan. While idle the level is zero; a trigger starts a linear rise to top_gain over
// attack_samples ticks, followed by a linear fall to zero over release_samples ticks; during
// both ramps further triggers are ignored. A tick inside a ramp needs a quotient
// top_gain*count/length, which is formed by a multiply step and then a shared restoring
// subtract-and-shift divider, so such a tick keeps the input not ready until the quotient
// has been moved into the output register. Idle ticks and the ticks that end a phase skip
// the divider. A finished result sits in an output register, so the next tick is
// accepted while it waits to be taken. Configuration writes are always accepted
// and must only be made while no tick is in flight; cfg_chan.data is the width of the wider
// of the two register kinds and each register keeps its low bits.
module attack_release_ramp_envelope #(
	parameter int unsigned COUNT_BITS = 20,
	parameter int unsigned LEVEL_BITS = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	arre_in_if.sink    in_chan,
	arre_out_if.source out_chan,
	arre_cfg_if.sink   cfg_chan
);

	localparam int unsigned PROD_BITS = COUNT_BITS + LEVEL_BITS;
	localparam int unsigned STEP_BITS = $clog2(LEVEL_BITS);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Configuration registers.
	logic [LEVEL_BITS-1:0] top_gain_q;
	logic [COUNT_BITS-1:0] attack_samples_q;
	logic [COUNT_BITS-1:0] release_samples_q;

	// Envelope state.
	logic [1:0]            phase_q;
	logic [COUNT_BITS-1:0] step_count_q;

	// Sequencer and divider registers.
	logic [1:0]            state_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [COUNT_BITS-1:0] divisor_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [LEVEL_BITS-1:0] quot_q;
	logic                  from_gain_q;
	logic                  active_q;

	// Output register.
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	logic                  out_active_q;

	logic                  in_fire;
	logic                  cfg_fire;
	logic                  out_free;
	logic [PROD_BITS-1:0]  product;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic [LEVEL_BITS-1:0] final_level;

	// Tick decision made at acceptance.
	logic [1:0]            next_phase;
	logic [COUNT_BITS-1:0] next_count;
	logic                  need_div;
	logic                  next_from_gain;
	logic [LEVEL_BITS-1:0] fast_level;
	logic [COUNT_BITS-1:0] next_divisor;

	assign in_fire  = in_chan.valid && in_chan.ready;
	assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
	assign out_free = !out_valid_q || out_chan.ready;

	assign in_chan.ready  = (state_q == ST_IDLE);
	assign cfg_chan.ready = 1'b1;

	assign out_chan.valid  = out_valid_q;
	assign out_chan.level  = out_level_q;
	assign out_chan.active = out_active_q;

	// Phase transition and operand selection for the tick being accepted.
	always_comb begin
		next_phase     = phase_q;
		next_count     = step_count_q;
		need_div       = 1'b0;
		next_from_gain = 1'b0;
		fast_level     = '0;
		next_divisor   = attack_samples_q;
		unique case (phase_q)
			arre_pkg::PH_ATTACK: begin
				if (step_count_q >= attack_samples_q) begin
					next_phase = arre_pkg::PH_RELEASE;
					next_count = '0;
					fast_level = top_gain_q;
				end else begin
					next_count = step_count_q + COUNT_BITS'(1);
					need_div   = 1'b1;
				end
			end
			arre_pkg::PH_RELEASE: begin
				next_divisor = release_samples_q;
				if (step_count_q >= release_samples_q) begin
					next_phase = arre_pkg::PH_IDLE;
					next_count = '0;
				end else begin
					next_count     = step_count_q + COUNT_BITS'(1);
					need_div       = 1'b1;
					next_from_gain = 1'b1;
				end
			end
			default: begin
				if (in_chan.trigger) begin
					next_phase = arre_pkg::PH_ATTACK;
					next_count = '0;
				end else begin
					next_phase = arre_pkg::PH_IDLE;
				end
			end
		endcase
	end

	// Gain times count, registered before the divider starts.
	assign product = PROD_BITS'(top_gain_q) * PROD_BITS'(step_count_q);

	// One restoring division step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quot_q[LEVEL_BITS-1]};
	assign diff  = trial - {1'b0, divisor_q};

	// Release levels count down from the peak.
	assign final_level = from_gain_q ? (top_gain_q - quot_q) : quot_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_gain_q        <= LEVEL_BITS'(65535);
			attack_samples_q  <= COUNT_BITS'(24000);
			release_samples_q <= COUNT_BITS'(24000);
		end else if (cfg_fire) begin
			unique case (cfg_chan.index)
				arre_pkg::REG_TOP_GAIN:        top_gain_q <= cfg_chan.data[LEVEL_BITS-1:0];
				arre_pkg::REG_ATTACK_SAMPLES:  attack_samples_q <= cfg_chan.data[COUNT_BITS-1:0];
				arre_pkg::REG_RELEASE_SAMPLES: release_samples_q <= cfg_chan.data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and envelope state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= arre_pkg::PH_IDLE;
			step_count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						phase_q      <= next_phase;
						step_count_q <= next_count;
						state_q      <= need_div ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				default: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Output valid: set when a result is loaded, held until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == ST_DONE) && out_free) || (out_valid_q && !out_chan.ready);
		end
	end

	// Divider datapath and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					divisor_q   <= next_divisor;
					from_gain_q <= next_from_gain;
					quot_q      <= fast_level;
					active_q    <= (next_phase != arre_pkg::PH_IDLE);
				end
			end
			ST_MUL: begin
				rem_q  <= product[PROD_BITS-1:LEVEL_BITS];
				quot_q <= product[LEVEL_BITS-1:0];
				step_q <= STEP_BITS'(LEVEL_BITS - 1);
			end
			ST_DIV: begin
				step_q <= step_q - STEP_BITS'(1);
				if (!diff[COUNT_BITS]) begin
					rem_q  <= diff[COUNT_BITS-1:0];
					quot_q <= {quot_q[LEVEL_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= trial[COUNT_BITS-1:0];
					quot_q <= {quot_q[LEVEL_BITS-2:0], 1'b0};
				end
			end
			default: begin
				if (out_free) begin
					out_level_q  <= final_level;
					out_active_q <= active_q;
				end
			end
		endcase
	end

endmodule

`default_nettype wire
